FILE: rtl/kv_block_free_list_allocator_top_macros.svh
// Assertion helpers shared by the allocator RTL.
`ifndef KV_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define KV_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVBFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define KVBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed (next cycle)");

`endif

FILE: rtl/kvbfl_pkg.sv
`timescale 1ns / 1ps

package kvbfl_pkg;

    localparam int POOL_BLOCKS = 1024;
    localparam int MAX_GRANT   = 64;

    localparam int ID_W    = 10;
    localparam int CNT_W   = 11;
    localparam int GRANT_W = 7;
    localparam int BUF_AW  = $clog2(MAX_GRANT);
    localparam int TPB_W   = 11;
    localparam int TOK_W   = 20;
    localparam int NUM_W   = 21;
    localparam int STEP_W  = $clog2(NUM_W);
    localparam int REQ_W   = 2;
    localparam int ST_W    = 4;

    typedef logic [ID_W-1:0]  t_block_id;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [ST_W-1:0]  t_status;
    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_ALLOC   = 2'd0;
    localparam t_req REQ_SEQ     = 2'd1;
    localparam t_req REQ_RELEASE = 2'd2;
    localparam t_req REQ_FREE    = 2'd3;

    localparam t_status ST_GRANT    = 4'd0;
    localparam t_status ST_NONE     = 4'd1;
    localparam t_status ST_SHORT    = 4'd2;
    localparam t_status ST_LARGE    = 4'd3;
    localparam t_status ST_RELEASED = 4'd4;
    localparam t_status ST_NOTUSED  = 4'd5;
    localparam t_status ST_FREED    = 4'd6;
    localparam t_status ST_RESERVED = 4'd7;
    localparam t_status ST_OVERFLOW = 4'd8;

    localparam logic [TPB_W-1:0] TPB_RESET = 11'd16;

endpackage

FILE: rtl/kvbfl_ram.sv
`timescale 1ns / 1ps

module kvbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last word read while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kv_block_free_list_allocator_top.sv
`timescale 1ns / 1ps
`include "kv_block_free_list_allocator_top_macros.svh"

// Fixed-size block allocator, free-id stack (smallest id on top after reset).
// Request channel: i_in_valid / o_in_ready with the request fields; one request
// is worked at a time and o_in_ready stays low until its last word is loaded.
// Result channel: o_out_valid / i_out_ready, one word per granted block or one
// status word; o_last_of_run marks the final word of a request. All words of a
// request carry the totals after the whole request.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes
// tokens_per_block; write it only while the block is idle.
// Steps per request:
//   allocate n blocks:      check, n pops (S_POP, S_MARKRD, S_MARK), n words out
//   allocate for sequence:  the bit-serial divider (S_DIV) first, then as above
//   release / free / reject: S_TGT or S_CHECK, then S_RESP
// The stack and in-use memories have one read port each, which sets the pop
// cost; the divider retires one quotient bit per cycle.
// After reset an init pass loads all 1024 stack slots and clears the in-use map;
// requests are held off meanwhile, config writes are still taken.
// A stalled receiver holds the output word; the sequencer waits on it.
module kv_block_free_list_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [kvbfl_pkg::REQ_W-1:0]   i_req_type,
    input  logic [kvbfl_pkg::GRANT_W-1:0] i_block_count,
    input  logic [kvbfl_pkg::TOK_W-1:0]   i_token_count,
    input  logic [kvbfl_pkg::CNT_W-1:0]   i_blocks_held,
    input  logic [kvbfl_pkg::ID_W-1:0]    i_target_block,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [kvbfl_pkg::ID_W-1:0]    o_granted_block,
    output logic [kvbfl_pkg::ST_W-1:0]    o_status,
    output logic                          o_last_of_run,
    output logic [kvbfl_pkg::CNT_W-1:0]   o_used_total,
    output logic [kvbfl_pkg::CNT_W-1:0]   o_free_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kvbfl_pkg::TPB_W-1:0]   i_tokens_per_block
);

    import kvbfl_pkg::*;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_CHECK   = 4'd3;
    localparam logic [3:0] S_TGT     = 4'd4;
    localparam logic [3:0] S_POP     = 4'd5;
    localparam logic [3:0] S_MARKRD  = 4'd6;
    localparam logic [3:0] S_MARK    = 4'd7;
    localparam logic [3:0] S_EMIT_RD = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    // control
    logic [3:0]        r_state, n_state;
    t_block_id         r_init, n_init;
    logic [STEP_W-1:0] r_step, n_step;
    logic [GRANT_W-1:0] r_idx, n_idx;
    t_count            r_depth, n_depth;
    t_count            r_used, n_used;
    logic [TPB_W-1:0]  r_tpb;
    logic              r_out_valid;

    // request payload
    t_req              r_req, n_req;
    t_block_id         r_target, n_target;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [NUM_W-1:0]  r_need, n_need;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [TPB_W-1:0]  r_rem, n_rem;
    logic [GRANT_W-1:0] r_cnt, n_cnt;
    t_status           r_res_status, n_res_status;

    // output word
    t_block_id         r_out_block;
    t_status           r_out_status;
    logic              r_out_last;
    t_count            r_out_used;
    t_count            r_out_free;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    t_block_id         out_block;
    t_status           out_status;
    logic              out_last;

    logic              stk_we, stk_re;
    t_block_id         stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic              map_we, map_re;
    t_block_id         map_waddr, map_raddr;
    logic [0:0]        map_wdata, map_rdata;
    logic              buf_we, buf_re;
    logic [BUF_AW-1:0] buf_waddr, buf_raddr;
    t_block_id         buf_wdata, buf_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic [TPB_W:0]   trial;
        logic             qbit;
        logic [NUM_W-1:0] diff;
        t_count           depth_dec;
        logic             is_last;

        n_state      = r_state;
        n_init       = r_init;
        n_step       = r_step;
        n_idx        = r_idx;
        n_depth      = r_depth;
        n_used       = r_used;
        n_req        = r_req;
        n_target     = r_target;
        n_held       = r_held;
        n_need       = r_need;
        n_num        = r_num;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;

        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;
        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = 1'b0;
        map_re    = 1'b0;
        map_raddr = '0;
        buf_we    = 1'b0;
        buf_waddr = '0;
        buf_wdata = '0;
        buf_re    = 1'b0;
        buf_raddr = '0;

        out_load   = 1'b0;
        out_block  = '0;
        out_status = ST_GRANT;
        out_last   = 1'b0;

        trial     = {r_rem, r_num[NUM_W-1]};
        qbit      = 1'b0;
        diff      = (r_need > NUM_W'(r_held)) ? (r_need - NUM_W'(r_held)) : '0;
        depth_dec = r_depth - CNT_W'(1);
        is_last   = ((r_idx + GRANT_W'(1)) == r_cnt);

        case (r_state)
            S_INIT: begin
                // load slot k with id N-1-k and clear mark k
                stk_we    = 1'b1;
                stk_waddr = r_init;
                stk_wdata = ID_W'(POOL_BLOCKS - 1) - r_init;
                map_we    = 1'b1;
                map_waddr = r_init;
                map_wdata = 1'b0;
                n_init    = r_init + ID_W'(1);
                if (r_init == ID_W'(POOL_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_req_type;
                    n_target = i_target_block;
                    case (i_req_type)
                        REQ_ALLOC: begin
                            n_need  = NUM_W'(i_block_count);
                            n_held  = '0;
                            n_state = S_CHECK;
                        end
                        REQ_SEQ: begin
                            n_held = i_blocks_held;
                            if (r_tpb == '0) begin
                                n_need  = '0;
                                n_state = S_CHECK;
                            end else begin
                                // ceil division: divide tokens + tpb - 1
                                n_num   = NUM_W'(i_token_count) + NUM_W'(r_tpb)
                                          - NUM_W'(1);
                                n_rem   = '0;
                                n_step  = '0;
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            map_re    = 1'b1;
                            map_raddr = i_target_block;
                            n_state   = S_TGT;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (trial >= {1'b0, r_tpb}) begin
                    n_rem = TPB_W'(trial - {1'b0, r_tpb});
                    qbit  = 1'b1;
                end else begin
                    n_rem = trial[TPB_W-1:0];
                end
                n_num  = {r_num[NUM_W-2:0], qbit};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_need  = {r_num[NUM_W-2:0], qbit};
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (diff == '0) begin
                    n_res_status = ST_NONE;
                    n_state      = S_RESP;
                end else if (diff > NUM_W'(MAX_GRANT)) begin
                    n_res_status = ST_LARGE;
                    n_state      = S_RESP;
                end else if (diff > NUM_W'(r_depth)) begin
                    n_res_status = ST_SHORT;
                    n_state      = S_RESP;
                end else begin
                    n_cnt   = GRANT_W'(diff);
                    n_idx   = '0;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                stk_re    = 1'b1;
                stk_raddr = depth_dec[ID_W-1:0];
                n_depth   = depth_dec;
                n_state   = S_MARKRD;
            end
            S_MARKRD: begin
                map_re    = 1'b1;
                map_raddr = stk_rdata;
                buf_we    = 1'b1;
                buf_waddr = r_idx[BUF_AW-1:0];
                buf_wdata = stk_rdata;
                n_state   = S_MARK;
            end
            S_MARK: begin
                // count only marks that were clear, so duplicates stay honest
                if (map_rdata == 1'b0) begin
                    map_we    = 1'b1;
                    map_waddr = stk_rdata;
                    map_wdata = 1'b1;
                    n_used    = r_used + CNT_W'(1);
                end
                if (is_last) begin
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_idx   = r_idx + GRANT_W'(1);
                    n_state = S_POP;
                end
            end
            S_EMIT_RD: begin
                buf_re    = 1'b1;
                buf_raddr = r_idx[BUF_AW-1:0];
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_block  = buf_rdata;
                    out_status = ST_GRANT;
                    out_last   = is_last;
                    n_idx      = r_idx + GRANT_W'(1);
                    n_state    = is_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_TGT: begin
                if (r_req == REQ_RELEASE) begin
                    if (map_rdata == 1'b1) begin
                        map_we       = 1'b1;
                        map_waddr    = r_target;
                        map_wdata    = 1'b0;
                        if (r_used != '0) begin
                            n_used = r_used - CNT_W'(1);
                        end
                        n_res_status = ST_RELEASED;
                    end else begin
                        n_res_status = ST_NOTUSED;
                    end
                end else if (r_target == '0) begin
                    n_res_status = ST_RESERVED;
                end else begin
                    map_we    = 1'b1;
                    map_waddr = r_target;
                    map_wdata = 1'b0;
                    if ((map_rdata == 1'b1) && (r_used != '0)) begin
                        n_used = r_used - CNT_W'(1);
                    end
                    if (r_depth >= CNT_W'(POOL_BLOCKS)) begin
                        n_res_status = ST_OVERFLOW;
                    end else begin
                        stk_we       = 1'b1;
                        stk_waddr    = r_depth[ID_W-1:0];
                        stk_wdata    = r_target;
                        n_depth      = r_depth + CNT_W'(1);
                        n_res_status = ST_FREED;
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_block  = '0;
                    out_status = r_res_status;
                    out_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init      <= '0;
            r_step      <= '0;
            r_idx       <= '0;
            r_depth     <= CNT_W'(POOL_BLOCKS - 1);
            r_used      <= '0;
            r_tpb       <= TPB_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_depth <= n_depth;
            r_used  <= n_used;
            if (i_cfg_valid) begin
                r_tpb <= i_tokens_per_block;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_target     <= n_target;
        r_held       <= n_held;
        r_need       <= n_need;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_block  <= out_block;
            r_out_status <= out_status;
            r_out_last   <= out_last;
            r_out_used   <= n_used;
            r_out_free   <= n_depth;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_block = r_out_block;
    assign o_status        = r_out_status;
    assign o_last_of_run   = r_out_last;
    assign o_used_total    = r_out_used;
    assign o_free_total    = r_out_free;

    kvbfl_ram #(
        .WIDTH (ID_W),
        .DEPTH (POOL_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    kvbfl_ram #(
        .WIDTH (1),
        .DEPTH (POOL_BLOCKS)
    ) u_in_use (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    kvbfl_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_GRANT)
    ) u_grant_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    `KVBFL_ASSERT_NEXT(a_pop_lowers_depth, i_clk, i_rst_n, (r_state == S_POP),
        (r_depth == ($past(r_depth) - CNT_W'(1))))
    `KVBFL_ASSERT_SAME(a_pop_has_stock, i_clk, i_rst_n, (r_state == S_POP), (r_depth != '0))
    `KVBFL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)
    `KVBFL_ASSERT_SAME(a_totals_bounded, i_clk, i_rst_n, 1'b1,
        ((r_depth <= CNT_W'(POOL_BLOCKS)) && (r_used <= CNT_W'(POOL_BLOCKS))))

endmodule
